@@ hw/rtl/abt_pkg.sv @@
// abt_pkg: constants, codes and types for the absorbing border taper
// no dependencies; imported by the channel interfaces and the top level
package abt_pkg;

	// sizes
	localparam int MAX_BORDER     = 64;
	localparam int MAX_INTERIOR   = 4096;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W         = COEF_FRAC_BITS + 1;
	localparam int ADDR_W         = (MAX_BORDER > 1) ? $clog2(MAX_BORDER) : 1;

	// field widths
	localparam int OPCODE_W   = 2;
	localparam int TIDX_W     = 6;
	localparam int DATA_W     = 32;
	localparam int DIM_W      = 13;
	localparam int BORDER_W   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// reset values of the geometry registers
	localparam logic [DIM_W-1:0]    RST_INTERIOR = DIM_W'(256);
	localparam logic [BORDER_W-1:0] RST_BORDER   = BORDER_W'(16);

	// coefficient of exactly one
	localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

	typedef enum logic [OPCODE_W-1:0] {
		OP_SAMPLE     = 2'd0,
		OP_LOAD_SIDE  = 2'd1,
		OP_LOAD_DEPTH = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERIOR_WIDTH = 3'd0,
		REG_INTERIOR_DEPTH = 3'd1,
		REG_SIDE_BORDER    = 3'd2,
		REG_DEPTH_BORDER   = 3'd3,
		REG_BORDER_MODE    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_MUL_S,
		ST_DONE
	} state_t;

	// low coefficient bits, saturated to one
	function automatic logic [COEF_W-1:0] coef_sat(input logic [DATA_W-1:0] raw);
		logic [COEF_W-1:0] c;
		c = raw[COEF_W-1:0];
		return (c > COEF_ONE) ? COEF_ONE : c;
	endfunction

endpackage

@@ hw/rtl/abt_if.sv @@
// abt channel interfaces: sample input, result output, register write port
// depends on abt_pkg for the field widths
interface sample_if;
	import abt_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic [TIDX_W-1:0]          table_index;
	logic signed [DATA_W-1:0]   data_value;

	modport source (output valid, opcode, table_index, data_value, input ready);
	modport sink   (input valid, opcode, table_index, data_value, output ready);
endinterface

interface result_if;
	import abt_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [DATA_W-1:0]   damped_sample;
	logic                       frame_last;

	modport source (output valid, damped_sample, frame_last, input ready);
	modport sink   (input valid, damped_sample, frame_last, output ready);
endinterface

interface cfg_if;
	import abt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_W-1:0]    index;
	logic [CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/absorbing_border_taper.sv @@
// absorbing_border_taper: border damping of a padded wavefield frame
// depends on abt_pkg and the interfaces in abt_if.sv
//
//   channel   dir  payload                                 beat when
//   cfg       in   index, data                             valid & ready
//   samples   in   opcode, table_index, data_value         valid & ready
//   results   out  damped_sample, frame_last               valid & ready
//
// A load beat writes the coefficient to its table at accept.
// A grid sample goes through table read, depth multiply, side multiply,
// then the result moves into the output register; samples.ready is low meanwhile.
// The output register holds a result while results.ready is low; a new sample
// is still accepted and stalls only in its last step until the register frees.
// Reset presets config, clears counters, valid, sequencer; tables stay undefined.
module absorbing_border_taper (
	input  logic      clk,
	input  logic      arst_n,
	cfg_if.sink       cfg,
	sample_if.sink    samples,
	result_if.source  results
);
	import abt_pkg::*;

	// configuration
	logic [DIM_W-1:0]    iw_q, id_q;
	logic [BORDER_W-1:0] sb_q, db_q;
	logic                mode_q;

	// frame position
	logic [DIM_W-1:0]    col_q, row_q;

	// geometry
	logic [DIM_W-1:0]    nx, nz;
	logic [BORDER_W-1:0] nxb, nzb;
	logic [DIM_W-1:0]    side_end, depth_end, width_all, depth_all;
	logic                top, bottom, left, right;
	logic                apply_d, apply_s, last;
	logic [ADDR_W-1:0]   depth_addr, side_addr, load_addr;

	// handshake
	logic                in_acc, is_sample, load_ok;
	logic                side_we, depth_we;
	logic [COEF_W-1:0]   load_coef;

	// coefficient tables
	logic [COEF_W-1:0]   side_mem  [MAX_BORDER];
	logic [COEF_W-1:0]   depth_mem [MAX_BORDER];
	logic [COEF_W-1:0]   side_rd_q, depth_rd_q;

	// sequencer
	state_t              state_q, state_d;
	logic                out_load;

	// datapath
	logic signed [DATA_W-1:0]          x_s1;
	logic                              apply_d_s1, apply_s_s1, last_s1;
	logic signed [DATA_W+COEF_W:0]     p1_s1;
	logic signed [DATA_W:0]            x1, x1_s2;
	logic signed [DATA_W+COEF_W+1:0]   p2_s2;
	logic signed [DATA_W+1:0]          x2;
	logic signed [DATA_W-1:0]          sat;

	// output register
	logic                              out_valid_q;
	logic signed [DATA_W-1:0]          out_sample_q;
	logic                              out_last_q;

	// clamped geometry and frame edges
	always_comb begin
		if (iw_q == '0)
			nx = DIM_W'(1);
		else if (iw_q > DIM_W'(MAX_INTERIOR))
			nx = DIM_W'(MAX_INTERIOR);
		else
			nx = iw_q;
		if (id_q == '0)
			nz = DIM_W'(1);
		else if (id_q > DIM_W'(MAX_INTERIOR))
			nz = DIM_W'(MAX_INTERIOR);
		else
			nz = id_q;
		nxb = (sb_q > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER) : sb_q;
		nzb = (db_q > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER) : db_q;
		side_end  = nx + DIM_W'(nxb);
		depth_end = nz + DIM_W'(nzb);
		width_all = side_end + DIM_W'(nxb);
		depth_all = depth_end + DIM_W'(nzb);
	end

	// border classification of the current position
	always_comb begin
		top        = row_q < DIM_W'(nzb);
		bottom     = row_q >= depth_end;
		left       = col_q < DIM_W'(nxb);
		right      = col_q >= side_end;
		apply_d    = top || (bottom && !mode_q);
		apply_s    = (!mode_q || top) && (left || right);
		last       = (col_q == width_all - DIM_W'(1)) && (row_q == depth_all - DIM_W'(1));
		depth_addr = top  ? ADDR_W'(row_q) : ADDR_W'(depth_all - row_q - DIM_W'(1));
		side_addr  = left ? ADDR_W'(col_q) : ADDR_W'(width_all - col_q - DIM_W'(1));
	end

	// input beat decode
	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign is_sample     = (samples.opcode == OP_SAMPLE);
	assign load_ok       = int'(samples.table_index) < MAX_BORDER;
	assign load_addr     = ADDR_W'(samples.table_index);
	assign load_coef     = coef_sat(samples.data_value);
	assign side_we       = in_acc && (samples.opcode == OP_LOAD_SIDE) && load_ok;
	assign depth_we      = in_acc && (samples.opcode == OP_LOAD_DEPTH) && load_ok;

	// side coefficient table
	always_ff @(posedge clk) begin
		if (side_we)
			side_mem[load_addr] <= load_coef;
		if (in_acc && is_sample)
			side_rd_q <= side_mem[side_addr];
	end

	// depth coefficient table
	always_ff @(posedge clk) begin
		if (depth_we)
			depth_mem[load_addr] <= load_coef;
		if (in_acc && is_sample)
			depth_rd_q <= depth_mem[depth_addr];
	end

	// configuration registers and frame counters
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q   <= RST_INTERIOR;
			id_q   <= RST_INTERIOR;
			sb_q   <= RST_BORDER;
			db_q   <= RST_BORDER;
			mode_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_INTERIOR_WIDTH: begin
					iw_q  <= cfg.data[DIM_W-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				REG_INTERIOR_DEPTH: begin
					id_q  <= cfg.data[DIM_W-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				REG_SIDE_BORDER: begin
					sb_q  <= cfg.data[BORDER_W-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				REG_DEPTH_BORDER: begin
					db_q  <= cfg.data[BORDER_W-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				REG_BORDER_MODE: begin
					mode_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end else if (in_acc && is_sample) begin
			// depth index runs fastest
			if (row_q == depth_all - DIM_W'(1)) begin
				row_q <= '0;
				col_q <= (col_q == width_all - DIM_W'(1)) ? '0 : col_q + DIM_W'(1);
			end else begin
				row_q <= row_q + DIM_W'(1);
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && is_sample)
					state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				state_d = ST_MUL_S;
			end
			ST_MUL_S: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// capture of the sample and its border flags
	always_ff @(posedge clk) begin
		if (in_acc && is_sample) begin
			x_s1       <= samples.data_value;
			apply_d_s1 <= apply_d;
			apply_s_s1 <= apply_s;
			last_s1    <= last;
		end
	end

	// depth factor, then side factor; floor shift is a plain bit select
	assign x1 = apply_d_s1 ? p1_s1[COEF_FRAC_BITS +: DATA_W+1] : {x_s1[DATA_W-1], x_s1};
	assign x2 = apply_s_s1 ? p2_s2[COEF_FRAC_BITS +: DATA_W+2] : {x1_s2[DATA_W], x1_s2};

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_D)
			p1_s1 <= x_s1 * $signed({1'b0, depth_rd_q});
		if (state_q == ST_MUL_S) begin
			x1_s2 <= x1;
			p2_s2 <= x1 * $signed({1'b0, side_rd_q});
		end
	end

	// saturation to the sample width
	always_comb begin
		if (x2 > $signed({{2{1'b0}}, {1'b0, {(DATA_W-1){1'b1}}}}))
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		else if (x2 < $signed({{2{1'b1}}, {1'b1, {(DATA_W-1){1'b0}}}}))
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		else
			sat = x2[DATA_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= sat;
			out_last_q   <= last_s1;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.damped_sample = out_sample_q;
	assign results.frame_last    = out_last_q;

endmodule
